/* hw/rtl/vrt_pkg.sv */
// shared constants, state encoding and controller/datapath interface types
`timescale 1ns / 1ps
`default_nettype none
package vrt_pkg;

   localparam int GRID_BITS = 5;
   localparam int GRID_SIZE = 1 << GRID_BITS;
   localparam int FRAC_BITS = 12;
   localparam int HALF_Q    = 1 << (FRAC_BITS - 1);
   localparam int EPS_Q     = 1;
   localparam int ORG_W     = 18;
   localparam int DIR_W     = 16;
   localparam int DIST_W    = 18;
   localparam int CELL_W    = 10;
   localparam int UNIT_W    = FRAC_BITS + 2;
   localparam int SUM_W     = 2 * DIR_W;
   localparam int ROOT_W    = DIR_W;
   localparam int FACE_W    = 26;
   localparam int T_W       = DIST_W + 1;
   localparam int NUM_W     = 36;
   localparam int DEN_W     = 18;
   localparam int ADDR_W    = 3 * GRID_BITS;
   localparam int MEM_DEPTH = 1 << ADDR_W;
   localparam int CNT_W     = ADDR_W;

   localparam logic [T_W-1:0] T_MAX = '1;
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_CAST  = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_SQ,
      ST_ROOT,
      ST_NORM_GO,
      ST_NORM_WAIT,
      ST_START_RD,
      ST_START_CHK,
      ST_FACE_GO,
      ST_FACE_WAIT,
      ST_CHOOSE,
      ST_STEP_CHK,
      ST_STEP_GO,
      ST_STEP_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic mem_clr;
      logic mem_wr;
      logic cnt_clr;
      logic cnt_inc;
      logic sel_clr;
      logic sel_inc;
      logic sq_step;
      logic root_step;
      logic div_start;
      logic div_face;
      logic norm_store;
      logic face_store;
      logic rd_step;
      logic step_take;
      logic step_commit;
      logic res_start;
      logic res_step;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic root_last;
      logic sel_last;
      logic sum_zero;
      logic div_done;
      logic start_solid;
      logic step_none;
      logic step_solid;
   } sts_type;

   function automatic logic in_grid(input logic signed [CELL_W-1:0] c);
      return c[CELL_W-1:GRID_BITS] == '0;
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic signed [CELL_W-1:0] x,
                                                  input logic signed [CELL_W-1:0] y,
                                                  input logic signed [CELL_W-1:0] z);
      return {x[GRID_BITS-1:0], y[GRID_BITS-1:0], z[GRID_BITS-1:0]};
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/vrt_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module vrt_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hw/rtl/vrt_div.sv */
// iterative restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module vrt_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [vrt_pkg::NUM_W-1:0] num,
   input  wire logic [vrt_pkg::DEN_W-1:0] den,
   output logic                           done,
   output logic      [vrt_pkg::NUM_W-1:0] quo
);

   localparam int CW = $clog2(vrt_pkg::NUM_W + 1);

   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [CW-1:0]               cnt_ff, cnt_in;
   logic [vrt_pkg::DEN_W:0]     rem_ff, rem_in;
   logic [vrt_pkg::NUM_W-1:0]   quo_ff, quo_in;
   logic [vrt_pkg::DEN_W-1:0]   den_ff, den_in;
   logic [vrt_pkg::DEN_W:0]     rem_sh;

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      rem_sh  = {rem_ff[vrt_pkg::DEN_W-1:0], quo_ff[vrt_pkg::NUM_W-1]};
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = num;
         den_in = den;
      end else if (run_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[vrt_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[vrt_pkg::NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(vrt_pkg::NUM_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule
`default_nettype wire

/* hw/rtl/vrt_ctrl.sv */
// sequencing state machine for grid writes and ray casts
`timescale 1ns / 1ps
`default_nettype none
module vrt_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic             req_cmd,
   input  wire vrt_pkg::sts_type sts,
   output vrt_pkg::cmd_type      cmd,
   output logic                  busy,
   output logic                  rsp_valid
);

   vrt_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         vrt_pkg::ST_CLEAR: begin
            if (sts.clear_last) state_in = vrt_pkg::ST_IDLE;
         end
         vrt_pkg::ST_IDLE: begin
            if (start) begin
               state_in = (req_cmd == vrt_pkg::CMD_CAST) ? vrt_pkg::ST_SQ : vrt_pkg::ST_WRITE;
            end
         end
         vrt_pkg::ST_WRITE: state_in = vrt_pkg::ST_IDLE;
         vrt_pkg::ST_SQ: begin
            if (sts.sel_last) state_in = vrt_pkg::ST_ROOT;
         end
         vrt_pkg::ST_ROOT: begin
            if (sts.root_last) begin
               state_in = sts.sum_zero ? vrt_pkg::ST_DONE : vrt_pkg::ST_NORM_GO;
            end
         end
         vrt_pkg::ST_NORM_GO: state_in = vrt_pkg::ST_NORM_WAIT;
         vrt_pkg::ST_NORM_WAIT: begin
            if (sts.div_done) begin
               state_in = sts.sel_last ? vrt_pkg::ST_START_RD : vrt_pkg::ST_NORM_GO;
            end
         end
         vrt_pkg::ST_START_RD: state_in = vrt_pkg::ST_START_CHK;
         vrt_pkg::ST_START_CHK: begin
            state_in = sts.start_solid ? vrt_pkg::ST_DONE : vrt_pkg::ST_FACE_GO;
         end
         vrt_pkg::ST_FACE_GO: state_in = vrt_pkg::ST_FACE_WAIT;
         vrt_pkg::ST_FACE_WAIT: begin
            if (sts.div_done) begin
               state_in = sts.sel_last ? vrt_pkg::ST_CHOOSE : vrt_pkg::ST_FACE_GO;
            end
         end
         vrt_pkg::ST_CHOOSE: begin
            state_in = sts.step_none ? vrt_pkg::ST_DONE : vrt_pkg::ST_STEP_CHK;
         end
         vrt_pkg::ST_STEP_CHK: begin
            state_in = sts.step_solid ? vrt_pkg::ST_DONE : vrt_pkg::ST_STEP_GO;
         end
         vrt_pkg::ST_STEP_GO: state_in = vrt_pkg::ST_STEP_WAIT;
         vrt_pkg::ST_STEP_WAIT: begin
            if (sts.div_done) state_in = vrt_pkg::ST_CHOOSE;
         end
         vrt_pkg::ST_DONE: state_in = vrt_pkg::ST_IDLE;
         default: state_in = vrt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      busy      = 1'b1;
      rsp_valid = 1'b0;
      unique case (state_ff)
         vrt_pkg::ST_CLEAR: begin
            cmd.mem_clr = 1'b1;
            cmd.cnt_inc = 1'b1;
         end
         vrt_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load    = 1'b1;
               cmd.sel_clr = 1'b1;
            end
         end
         vrt_pkg::ST_WRITE: cmd.mem_wr = 1'b1;
         vrt_pkg::ST_SQ: begin
            cmd.sq_step = 1'b1;
            cmd.sel_inc = 1'b1;
            cmd.cnt_clr = 1'b1;
         end
         vrt_pkg::ST_ROOT: begin
            cmd.root_step = 1'b1;
            cmd.cnt_inc   = 1'b1;
            cmd.sel_clr   = 1'b1;
         end
         vrt_pkg::ST_NORM_GO: cmd.div_start = 1'b1;
         vrt_pkg::ST_NORM_WAIT: begin
            if (sts.div_done) begin
               cmd.norm_store = 1'b1;
               cmd.sel_inc    = ~sts.sel_last;
            end
         end
         vrt_pkg::ST_START_RD: ;
         vrt_pkg::ST_START_CHK: begin
            cmd.res_start = sts.start_solid;
            cmd.sel_clr   = 1'b1;
         end
         vrt_pkg::ST_FACE_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_face  = 1'b1;
         end
         vrt_pkg::ST_FACE_WAIT: begin
            cmd.div_face = 1'b1;
            if (sts.div_done) begin
               cmd.face_store = 1'b1;
               cmd.sel_inc    = ~sts.sel_last;
            end
         end
         vrt_pkg::ST_CHOOSE: begin
            cmd.rd_step   = 1'b1;
            cmd.step_take = ~sts.step_none;
         end
         vrt_pkg::ST_STEP_CHK: begin
            cmd.res_step    = sts.step_solid;
            cmd.step_commit = ~sts.step_solid;
         end
         vrt_pkg::ST_STEP_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_face  = 1'b1;
         end
         vrt_pkg::ST_STEP_WAIT: begin
            cmd.div_face   = 1'b1;
            cmd.face_store = sts.div_done;
         end
         vrt_pkg::ST_DONE: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= vrt_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/vrt_dp.sv */
// datapath: occupancy grid, normalization, face distances and walk state
`timescale 1ns / 1ps
`default_nettype none
module vrt_dp (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire vrt_pkg::cmd_type                    cmd,
   output vrt_pkg::sts_type                         sts,
   input  wire logic [vrt_pkg::GRID_BITS-1:0]       req_cell_x,
   input  wire logic [vrt_pkg::GRID_BITS-1:0]       req_cell_y,
   input  wire logic [vrt_pkg::GRID_BITS-1:0]       req_cell_z,
   input  wire logic                                req_solid,
   input  wire logic signed [vrt_pkg::ORG_W-1:0]    req_origin_x,
   input  wire logic signed [vrt_pkg::ORG_W-1:0]    req_origin_y,
   input  wire logic signed [vrt_pkg::ORG_W-1:0]    req_origin_z,
   input  wire logic signed [vrt_pkg::DIR_W-1:0]    req_dir_x,
   input  wire logic signed [vrt_pkg::DIR_W-1:0]    req_dir_y,
   input  wire logic signed [vrt_pkg::DIR_W-1:0]    req_dir_z,
   input  wire logic [vrt_pkg::DIST_W-1:0]          req_max_distance,
   output logic                                     rsp_hit,
   output logic [vrt_pkg::GRID_BITS-1:0]            rsp_block_x,
   output logic [vrt_pkg::GRID_BITS-1:0]            rsp_block_y,
   output logic [vrt_pkg::GRID_BITS-1:0]            rsp_block_z,
   output logic signed [1:0]                        rsp_normal_x,
   output logic signed [1:0]                        rsp_normal_y,
   output logic signed [1:0]                        rsp_normal_z,
   output logic [vrt_pkg::DIST_W-1:0]               rsp_hit_distance
);

   localparam int CELL_W = vrt_pkg::CELL_W;
   localparam int UNIT_W = vrt_pkg::UNIT_W;
   localparam int FACE_W = vrt_pkg::FACE_W;
   localparam int T_W    = vrt_pkg::T_W;

   // counters
   logic [vrt_pkg::CNT_W-1:0]  cnt_ff;
   logic [1:0]                 sel_ff;

   // request payload
   logic [vrt_pkg::ADDR_W-1:0]        waddr_ff;
   logic                              wsolid_ff;
   logic signed [vrt_pkg::ORG_W-1:0]  org_ff [3];
   logic signed [vrt_pkg::DIR_W-1:0]  dir_ff [3];
   logic [vrt_pkg::DIST_W-1:0]        maxd_ff;

   // walk state
   logic [vrt_pkg::SUM_W-1:0]   sum_ff;
   logic [vrt_pkg::ROOT_W-1:0]  root_ff;
   logic signed [UNIT_W-1:0]    unit_ff [3];
   logic signed [CELL_W-1:0]    cur_ff [3];
   logic signed [CELL_W-1:0]    nxt_ff [3];
   logic [T_W-1:0]              t_ff [3];
   logic [2:0]                  tv_ff;
   logic [1:0]                  ax_ff;
   logic [T_W-1:0]              len_ff;

   // result
   logic                            hit_ff;
   logic [vrt_pkg::GRID_BITS-1:0]   blk_ff [3];
   logic signed [1:0]               nrm_ff [3];
   logic [vrt_pkg::DIST_W-1:0]      dist_ff;

   logic signed [CELL_W-1:0]    start_cell [3];
   logic signed [vrt_pkg::ORG_W:0] org_half [3];
   logic signed [vrt_pkg::DIR_W-1:0] req_dir [3];
   logic signed [vrt_pkg::ORG_W-1:0] req_org [3];

   logic [vrt_pkg::DIR_W-1:0]   dabs;
   logic [vrt_pkg::SUM_W-1:0]   dsq;
   logic [vrt_pkg::ROOT_W-1:0]  cand;
   logic [vrt_pkg::SUM_W-1:0]   cand_sq;

   logic signed [FACE_W-1:0]    fnum_s;
   logic [FACE_W-1:0]           fmag;
   logic [UNIT_W-2:0]           uabs;
   logic [vrt_pkg::NUM_W-1:0]   div_num;
   logic [vrt_pkg::DEN_W-1:0]   div_den;
   logic                        div_done;
   logic [vrt_pkg::NUM_W-1:0]   div_quo;
   logic [UNIT_W-2:0]           qmag;
   logic [T_W-1:0]              t_sat;

   logic [T_W-1:0]              tn;
   logic [1:0]                  ax;
   logic                        found;
   logic signed [CELL_W-1:0]    nxt [3];

   logic                        mem_we;
   logic [vrt_pkg::ADDR_W-1:0]  mem_waddr;
   logic [vrt_pkg::ADDR_W-1:0]  mem_raddr;
   logic                        mem_rdata;

   assign req_dir[0] = req_dir_x;
   assign req_dir[1] = req_dir_y;
   assign req_dir[2] = req_dir_z;
   assign req_org[0] = req_origin_x;
   assign req_org[1] = req_origin_y;
   assign req_org[2] = req_origin_z;

   // cell holding the origin: floor(o + 1/2)
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         org_half[a]   = (vrt_pkg::ORG_W + 1)'(req_org[a])
                         + (vrt_pkg::ORG_W + 1)'(vrt_pkg::HALF_Q);
         start_cell[a] = CELL_W'(org_half[a] >>> vrt_pkg::FRAC_BITS);
      end
   end

   // squared length and bitwise root
   always_comb begin
      dabs    = dir_ff[sel_ff][vrt_pkg::DIR_W-1] ? vrt_pkg::DIR_W'(-dir_ff[sel_ff])
                                                 : vrt_pkg::DIR_W'(dir_ff[sel_ff]);
      dsq     = dabs * dabs;
      cand    = root_ff | (vrt_pkg::ROOT_W'(1) << (4'd15 - cnt_ff[3:0]));
      cand_sq = cand * cand;
   end

   // divider operands: normalization or face distance of the selected axis
   always_comb begin
      fnum_s = (FACE_W'(cur_ff[sel_ff]) <<< vrt_pkg::FRAC_BITS)
               + ((unit_ff[sel_ff] > 0) ? FACE_W'(vrt_pkg::HALF_Q) : -FACE_W'(vrt_pkg::HALF_Q))
               - FACE_W'(org_ff[sel_ff]);
      fmag   = fnum_s[FACE_W-1] ? FACE_W'(-fnum_s) : FACE_W'(fnum_s);
      uabs   = unit_ff[sel_ff][UNIT_W-1] ? (UNIT_W-1)'(-unit_ff[sel_ff])
                                         : (UNIT_W-1)'(unit_ff[sel_ff]);
      if (cmd.div_face) begin
         div_num = vrt_pkg::NUM_W'(fmag) << vrt_pkg::FRAC_BITS;
         div_den = vrt_pkg::DEN_W'(uabs);
      end else begin
         div_num = (vrt_pkg::NUM_W'(dabs) << (vrt_pkg::FRAC_BITS + 1))
                   + vrt_pkg::NUM_W'(root_ff);
         div_den = vrt_pkg::DEN_W'({root_ff, 1'b0});
      end
      qmag  = div_quo[UNIT_W-2:0];
      t_sat = (div_quo > vrt_pkg::NUM_W'(vrt_pkg::T_MAX)) ? vrt_pkg::T_MAX : div_quo[T_W-1:0];
   end

   vrt_div u_div (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // nearest face, x before y before z on ties
   always_comb begin
      tn    = {1'b0, maxd_ff};
      ax    = 2'd0;
      found = 1'b0;
      for (int a = 0; a < 3; a++) begin
         if (tv_ff[a] && (t_ff[a] < tn)) begin
            tn    = t_ff[a];
            ax    = 2'(a);
            found = 1'b1;
         end
      end
      for (int a = 0; a < 3; a++) begin
         if (found && (ax == 2'(a))) begin
            nxt[a] = unit_ff[a][UNIT_W-1] ? cur_ff[a] - 1'b1 : cur_ff[a] + 1'b1;
         end else begin
            nxt[a] = cur_ff[a];
         end
      end
   end

   always_comb begin
      mem_we    = cmd.mem_clr | cmd.mem_wr;
      mem_waddr = cmd.mem_clr ? cnt_ff : waddr_ff;
      mem_raddr = cmd.rd_step ? vrt_pkg::cell_addr(nxt[0], nxt[1], nxt[2])
                              : vrt_pkg::cell_addr(cur_ff[0], cur_ff[1], cur_ff[2]);
   end

   vrt_ram #(
      .WIDTH (1),
      .DEPTH (vrt_pkg::MEM_DEPTH)
   ) u_occ (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (cmd.mem_wr & wsolid_ff),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   always_comb begin
      sts.clear_last  = cnt_ff == vrt_pkg::CNT_W'(vrt_pkg::MEM_DEPTH - 1);
      sts.root_last   = cnt_ff[3:0] == 4'd15;
      sts.sel_last    = sel_ff == 2'd2;
      sts.sum_zero    = sum_ff == '0;
      sts.div_done    = div_done;
      sts.start_solid = mem_rdata & vrt_pkg::in_grid(cur_ff[0]) & vrt_pkg::in_grid(cur_ff[1])
                        & vrt_pkg::in_grid(cur_ff[2]);
      sts.step_none   = !(len_ff < {1'b0, maxd_ff}) || !found;
      sts.step_solid  = mem_rdata & vrt_pkg::in_grid(nxt_ff[0]) & vrt_pkg::in_grid(nxt_ff[1])
                        & vrt_pkg::in_grid(nxt_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         sel_ff <= '0;
      end else begin
         if (cmd.cnt_clr) begin
            cnt_ff <= '0;
         end else if (cmd.cnt_inc) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         // a step selects its own axis for the next face distance
         if (cmd.sel_clr) begin
            sel_ff <= '0;
         end else if (cmd.step_take) begin
            sel_ff <= ax;
         end else if (cmd.sel_inc) begin
            sel_ff <= sel_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         waddr_ff  <= {req_cell_x, req_cell_y, req_cell_z};
         wsolid_ff <= req_solid;
         maxd_ff   <= req_max_distance;
         sum_ff    <= '0;
         root_ff   <= '0;
         len_ff    <= '0;
         tv_ff     <= '0;
         hit_ff    <= 1'b0;
         dist_ff   <= '0;
         for (int a = 0; a < 3; a++) begin
            org_ff[a] <= req_org[a];
            dir_ff[a] <= req_dir[a];
            cur_ff[a] <= start_cell[a];
            blk_ff[a] <= '0;
            nrm_ff[a] <= '0;
         end
      end
      if (cmd.sq_step) begin
         sum_ff <= sum_ff + dsq;
      end
      if (cmd.root_step && (cand_sq <= sum_ff)) begin
         root_ff <= cand;
      end
      if (cmd.norm_store) begin
         unit_ff[sel_ff] <= dir_ff[sel_ff][vrt_pkg::DIR_W-1] ? -UNIT_W'(qmag) : UNIT_W'(qmag);
      end
      if (cmd.face_store) begin
         t_ff[sel_ff]  <= t_sat;
         tv_ff[sel_ff] <= unit_ff[sel_ff] != '0;
      end
      if (cmd.step_take) begin
         ax_ff  <= ax;
         len_ff <= tn + T_W'(vrt_pkg::EPS_Q);
         for (int a = 0; a < 3; a++) begin
            nxt_ff[a] <= nxt[a];
         end
      end
      if (cmd.step_commit) begin
         for (int a = 0; a < 3; a++) begin
            cur_ff[a] <= nxt_ff[a];
         end
      end
      if (cmd.res_start) begin
         hit_ff  <= 1'b1;
         dist_ff <= '0;
         for (int a = 0; a < 3; a++) begin
            blk_ff[a] <= cur_ff[a][vrt_pkg::GRID_BITS-1:0];
            if (unit_ff[a] > 0) begin
               nrm_ff[a] <= -2'sd1;
            end else if (unit_ff[a] < 0) begin
               nrm_ff[a] <= 2'sd1;
            end else begin
               nrm_ff[a] <= 2'sd0;
            end
         end
      end
      if (cmd.res_step) begin
         hit_ff  <= 1'b1;
         dist_ff <= len_ff[T_W-1] ? '1 : len_ff[vrt_pkg::DIST_W-1:0];
         for (int a = 0; a < 3; a++) begin
            blk_ff[a] <= nxt_ff[a][vrt_pkg::GRID_BITS-1:0];
            if (ax_ff == 2'(a)) begin
               nrm_ff[a] <= unit_ff[a][UNIT_W-1] ? 2'sd1 : -2'sd1;
            end else begin
               nrm_ff[a] <= 2'sd0;
            end
         end
      end
   end

   assign rsp_hit          = hit_ff;
   assign rsp_block_x      = blk_ff[0];
   assign rsp_block_y      = blk_ff[1];
   assign rsp_block_z      = blk_ff[2];
   assign rsp_normal_x     = nrm_ff[0];
   assign rsp_normal_y     = nrm_ff[1];
   assign rsp_normal_z     = nrm_ff[2];
   assign rsp_hit_distance = dist_ff;

endmodule
`default_nettype wire

/* hw/rtl/voxel_ray_traversal.sv */
// voxel ray traversal top level: controller plus datapath
`timescale 1ns / 1ps
`default_nettype none
// A 32x32x32 one-bit occupancy grid with a ray caster. After reset the block
// clears all 32768 cells of the grid with busy high. A request is taken when
// start is high and busy is low; req_cmd low writes one cell (no response),
// req_cmd high casts a ray and produces one response, shown for a single
// cycle with rsp_valid; the receiver cannot stall it. A cast runs the squares,
// the 16-step root and six divisions, then walks cell by cell, the shared
// bit-serial divider recomputing one face distance per step.
module voxel_ray_traversal (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic                             req_cmd,
   input  wire logic [vrt_pkg::GRID_BITS-1:0]    req_cell_x,
   input  wire logic [vrt_pkg::GRID_BITS-1:0]    req_cell_y,
   input  wire logic [vrt_pkg::GRID_BITS-1:0]    req_cell_z,
   input  wire logic                             req_solid,
   input  wire logic signed [vrt_pkg::ORG_W-1:0] req_origin_x,
   input  wire logic signed [vrt_pkg::ORG_W-1:0] req_origin_y,
   input  wire logic signed [vrt_pkg::ORG_W-1:0] req_origin_z,
   input  wire logic signed [vrt_pkg::DIR_W-1:0] req_dir_x,
   input  wire logic signed [vrt_pkg::DIR_W-1:0] req_dir_y,
   input  wire logic signed [vrt_pkg::DIR_W-1:0] req_dir_z,
   input  wire logic [vrt_pkg::DIST_W-1:0]       req_max_distance,
   output logic                                  rsp_valid,
   output logic                                  rsp_hit,
   output logic [vrt_pkg::GRID_BITS-1:0]         rsp_block_x,
   output logic [vrt_pkg::GRID_BITS-1:0]         rsp_block_y,
   output logic [vrt_pkg::GRID_BITS-1:0]         rsp_block_z,
   output logic signed [1:0]                     rsp_normal_x,
   output logic signed [1:0]                     rsp_normal_y,
   output logic signed [1:0]                     rsp_normal_z,
   output logic [vrt_pkg::DIST_W-1:0]            rsp_hit_distance
);

   vrt_pkg::cmd_type cmd;
   vrt_pkg::sts_type sts;

   vrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_cmd   (req_cmd),
      .sts       (sts),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   vrt_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_cell_x       (req_cell_x),
      .req_cell_y       (req_cell_y),
      .req_cell_z       (req_cell_z),
      .req_solid        (req_solid),
      .req_origin_x     (req_origin_x),
      .req_origin_y     (req_origin_y),
      .req_origin_z     (req_origin_z),
      .req_dir_x        (req_dir_x),
      .req_dir_y        (req_dir_y),
      .req_dir_z        (req_dir_z),
      .req_max_distance (req_max_distance),
      .rsp_hit          (rsp_hit),
      .rsp_block_x      (rsp_block_x),
      .rsp_block_y      (rsp_block_y),
      .rsp_block_z      (rsp_block_z),
      .rsp_normal_x     (rsp_normal_x),
      .rsp_normal_y     (rsp_normal_y),
      .rsp_normal_z     (rsp_normal_z),
      .rsp_hit_distance (rsp_hit_distance)
   );

endmodule
`default_nettype wire

/* hw/rtl/vrt_checker.sv */
// port-level checker for the ray traversal block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module vrt_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             busy,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_hit,
   input wire logic [vrt_pkg::GRID_BITS-1:0]    rsp_block_x,
   input wire logic [vrt_pkg::GRID_BITS-1:0]    rsp_block_y,
   input wire logic [vrt_pkg::GRID_BITS-1:0]    rsp_block_z,
   input wire logic signed [1:0]                rsp_normal_x,
   input wire logic signed [1:0]                rsp_normal_y,
   input wire logic signed [1:0]                rsp_normal_z,
   input wire logic [vrt_pkg::DIST_W-1:0]       rsp_hit_distance
);

   // grid clear runs right after reset
   assert property (@(posedge clock) reset |=> busy)
      else $error("busy low right after reset");

   // a response only ends a request in progress
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("response without a request in progress");

   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

   // a miss carries all-zero fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_block_x == '0 && rsp_block_y == '0 &&
         rsp_block_z == '0 && rsp_normal_x == '0 && rsp_normal_y == '0 &&
         rsp_normal_z == '0 && rsp_hit_distance == '0))
      else $error("miss response with nonzero fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_normal_x != 2'b10 && rsp_normal_y != 2'b10 && rsp_normal_z != 2'b10))
      else $error("normal component out of range");

endmodule

bind voxel_ray_traversal vrt_checker u_vrt_checker (.*);
`default_nettype wire

/* verif/tb_voxel_ray_traversal.sv */
// self-checking testbench for the voxel ray traversal block
`timescale 1ns / 1ps
`default_nettype none
module tb_voxel_ray_traversal;

   localparam int  RANDOM_ITEMS = 500;
   localparam longint CYCLE_LIMIT = 25000000;
   localparam longint ONE = 4096;

   typedef struct {
      logic                             cmd;
      logic [vrt_pkg::GRID_BITS-1:0]    cx, cy, cz;
      logic                             solid;
      logic signed [vrt_pkg::ORG_W-1:0] ox, oy, oz;
      logic signed [vrt_pkg::DIR_W-1:0] dx, dy, dz;
      logic [vrt_pkg::DIST_W-1:0]       maxd;
   } ray_req_type;

   typedef struct {
      logic                          hit;
      logic [vrt_pkg::GRID_BITS-1:0] bx, by, bz;
      logic signed [1:0]             nx, ny, nz;
      logic [vrt_pkg::DIST_W-1:0]    hdist;
   } ray_rsp_type;

   typedef struct {
      ray_req_type req;
      bit          known;
      ray_rsp_type rsp;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_cmd = vrt_pkg::CMD_WRITE;
   logic [vrt_pkg::GRID_BITS-1:0] req_cell_x = '0, req_cell_y = '0, req_cell_z = '0;
   logic req_solid = 1'b0;
   logic signed [vrt_pkg::ORG_W-1:0] req_origin_x = '0, req_origin_y = '0, req_origin_z = '0;
   logic signed [vrt_pkg::DIR_W-1:0] req_dir_x = '0, req_dir_y = '0, req_dir_z = '0;
   logic [vrt_pkg::DIST_W-1:0] req_max_distance = '0;
   logic rsp_valid, rsp_hit;
   logic [vrt_pkg::GRID_BITS-1:0] rsp_block_x, rsp_block_y, rsp_block_z;
   logic signed [1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic [vrt_pkg::DIST_W-1:0] rsp_hit_distance;

   bit          occ_grid [vrt_pkg::MEM_DEPTH];
   ray_rsp_type pending_hits [$];
   int          mismatches = 0;
   int          writes_sent = 0, casts_sent = 0, hits_seen = 0, rsp_seen = 0;
   longint      cycles = 0;

   voxel_ray_traversal u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_cmd(req_cmd), .req_cell_x(req_cell_x), .req_cell_y(req_cell_y),
      .req_cell_z(req_cell_z), .req_solid(req_solid),
      .req_origin_x(req_origin_x), .req_origin_y(req_origin_y),
      .req_origin_z(req_origin_z), .req_dir_x(req_dir_x), .req_dir_y(req_dir_y),
      .req_dir_z(req_dir_z), .req_max_distance(req_max_distance),
      .rsp_valid(rsp_valid), .rsp_hit(rsp_hit), .rsp_block_x(rsp_block_x),
      .rsp_block_y(rsp_block_y), .rsp_block_z(rsp_block_z),
      .rsp_normal_x(rsp_normal_x), .rsp_normal_y(rsp_normal_y),
      .rsp_normal_z(rsp_normal_z), .rsp_hit_distance(rsp_hit_distance)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending", cycles,
                  pending_hits.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic bit cell_solid(longint x, longint y, longint z);
      if (x < 0 || x >= vrt_pkg::GRID_SIZE || y < 0 || y >= vrt_pkg::GRID_SIZE ||
          z < 0 || z >= vrt_pkg::GRID_SIZE)
         return 1'b0;
      return occ_grid[(x * vrt_pkg::GRID_SIZE + y) * vrt_pkg::GRID_SIZE + z];
   endfunction

   // walks the ray cell by cell; returns the response a cast should give
   function automatic ray_rsp_type trace_ray(ray_req_type r);
      longint o[3], d[3], u[3], cur[3], nxt[3];
      longint sum, len, cand, mag, q, num, t, tn, walked, maxd;
      int ax;
      bit done;
      ray_rsp_type res;
      res = '{default: '0};
      o[0] = r.ox; o[1] = r.oy; o[2] = r.oz;
      d[0] = r.dx; d[1] = r.dy; d[2] = r.dz;
      maxd = r.maxd;
      sum = 0;
      for (int a = 0; a < 3; a++) sum += d[a] * d[a];
      if (sum == 0) return res;
      len = 0;
      for (int i = 15; i >= 0; i--) begin
         cand = len | (longint'(1) << i);
         if (cand * cand <= sum) len = cand;
      end
      for (int a = 0; a < 3; a++) begin
         mag = (d[a] < 0 ? -d[a] : d[a]) * ONE;
         q = (2 * mag + len) / (2 * len);
         u[a] = d[a] < 0 ? -q : q;
         cur[a] = (o[a] + vrt_pkg::HALF_Q) >>> vrt_pkg::FRAC_BITS;
      end
      if (cell_solid(cur[0], cur[1], cur[2])) begin
         res.hit = 1'b1;
         res.bx = cur[0][4:0]; res.by = cur[1][4:0]; res.bz = cur[2][4:0];
         res.nx = u[0] > 0 ? -2'sd1 : (u[0] < 0 ? 2'sd1 : 2'sd0);
         res.ny = u[1] > 0 ? -2'sd1 : (u[1] < 0 ? 2'sd1 : 2'sd0);
         res.nz = u[2] > 0 ? -2'sd1 : (u[2] < 0 ? 2'sd1 : 2'sd0);
         return res;
      end
      walked = 0;
      done = 1'b0;
      while (!done && walked < maxd) begin
         tn = maxd;
         ax = -1;
         for (int a = 0; a < 3; a++) begin
            if (u[a] != 0) begin
               num = u[a] > 0 ? cur[a] * ONE + vrt_pkg::HALF_Q - o[a]
                              : cur[a] * ONE - vrt_pkg::HALF_Q - o[a];
               if (num < 0) num = -num;
               t = (num * ONE) / (u[a] < 0 ? -u[a] : u[a]);
               if (t < tn) begin
                  tn = t;
                  ax = a;
               end
            end
         end
         if (ax < 0) begin
            done = 1'b1;
         end else begin
            walked = tn + vrt_pkg::EPS_Q;
            nxt = cur;
            nxt[ax] += u[ax] > 0 ? 1 : -1;
            if (cell_solid(nxt[0], nxt[1], nxt[2])) begin
               res.hit = 1'b1;
               res.bx = nxt[0][4:0]; res.by = nxt[1][4:0]; res.bz = nxt[2][4:0];
               res.nx = 2'(cur[0] - nxt[0]);
               res.ny = 2'(cur[1] - nxt[1]);
               res.nz = 2'(cur[2] - nxt[2]);
               res.hdist = walked > 262143 ? '1 : walked[vrt_pkg::DIST_W-1:0];
               done = 1'b1;
            end
            cur = nxt;
         end
      end
      return res;
   endfunction

   function automatic ray_req_type mk_write(int x, int y, int z, bit s);
      ray_req_type r;
      r = '{default: '0};
      r.cmd = vrt_pkg::CMD_WRITE;
      r.cx = vrt_pkg::GRID_BITS'(x);
      r.cy = vrt_pkg::GRID_BITS'(y);
      r.cz = vrt_pkg::GRID_BITS'(z);
      r.solid = s;
      return r;
   endfunction

   function automatic ray_req_type mk_cast(int ox, int oy, int oz, int dx, int dy, int dz,
                                           int maxd);
      ray_req_type r;
      r = '{default: '0};
      r.cmd = vrt_pkg::CMD_CAST;
      r.ox = vrt_pkg::ORG_W'(ox); r.oy = vrt_pkg::ORG_W'(oy); r.oz = vrt_pkg::ORG_W'(oz);
      r.dx = vrt_pkg::DIR_W'(dx); r.dy = vrt_pkg::DIR_W'(dy); r.dz = vrt_pkg::DIR_W'(dz);
      r.maxd = vrt_pkg::DIST_W'(maxd);
      return r;
   endfunction

   function automatic int rand_dir();
      case ($urandom_range(0, 4))
         0: return 0;
         1: return $urandom_range(0, 6) - 3;
         2: return $urandom_range(0, 8192) - 4096;
         default: return int'($signed(16'($urandom)));
      endcase
   endfunction

   function automatic logic [vrt_pkg::ORG_W-1:0] rand_org();
      longint v;
      v = longint'($urandom_range(6, 25)) * ONE + longint'($urandom_range(0, 4095)) - 2048;
      return vrt_pkg::ORG_W'(v);
   endfunction

   // writes and casts mostly clustered around the middle of the grid so rays find walls; some requests are fully random
   function automatic ray_req_type rand_req();
      ray_req_type r;
      int pick;
      r.cmd = 1'($urandom);
      r.cx = vrt_pkg::GRID_BITS'($urandom);
      r.cy = vrt_pkg::GRID_BITS'($urandom);
      r.cz = vrt_pkg::GRID_BITS'($urandom);
      r.solid = 1'($urandom);
      r.ox = vrt_pkg::ORG_W'($urandom); r.oy = vrt_pkg::ORG_W'($urandom);
      r.oz = vrt_pkg::ORG_W'($urandom);
      r.dx = vrt_pkg::DIR_W'($urandom); r.dy = vrt_pkg::DIR_W'($urandom);
      r.dz = vrt_pkg::DIR_W'($urandom);
      r.maxd = vrt_pkg::DIST_W'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         r.cmd = vrt_pkg::CMD_WRITE;
         if ($urandom_range(0, 4) != 0) begin
            r.cx = vrt_pkg::GRID_BITS'($urandom_range(8, 23));
            r.cy = vrt_pkg::GRID_BITS'($urandom_range(8, 23));
            r.cz = vrt_pkg::GRID_BITS'($urandom_range(8, 23));
         end
         r.solid = $urandom_range(0, 9) < 7;
      end else if (pick < 90) begin
         r.cmd = vrt_pkg::CMD_CAST;
         r.ox = rand_org(); r.oy = rand_org(); r.oz = rand_org();
         r.dx = vrt_pkg::DIR_W'(rand_dir());
         r.dy = vrt_pkg::DIR_W'(rand_dir());
         r.dz = vrt_pkg::DIR_W'(rand_dir());
         if ($urandom_range(0, 9) != 0)
            r.maxd = vrt_pkg::DIST_W'($urandom_range(0, 16 * ONE));
      end
      return r;
   endfunction

   // holds the request until busy is low ahead of a rising edge, then returns at that edge
   task automatic send(ray_req_type r, bit known, ray_rsp_type fixed);
      ray_rsp_type pred;
      req_cmd <= r.cmd;
      req_cell_x <= r.cx; req_cell_y <= r.cy; req_cell_z <= r.cz;
      req_solid <= r.solid;
      req_origin_x <= r.ox; req_origin_y <= r.oy; req_origin_z <= r.oz;
      req_dir_x <= r.dx; req_dir_y <= r.dy; req_dir_z <= r.dz;
      req_max_distance <= r.maxd;
      start <= 1'b1;
      do @(negedge clock); while (busy);
      @(posedge clock);
      if (r.cmd == vrt_pkg::CMD_WRITE) begin
         occ_grid[{r.cx, r.cy, r.cz}] = r.solid;
         writes_sent++;
      end else begin
         pred = trace_ray(r);
         pending_hits.push_back(known ? fixed : pred);
         casts_sent++;
      end
   endtask

   // response checker
   always @(posedge clock) begin
      ray_rsp_type want;
      if (!reset && rsp_valid) begin
         rsp_seen++;
         if (rsp_hit) hits_seen++;
         if (pending_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response at cycle %0d", cycles);
         end else begin
            want = pending_hits.pop_front();
            if (rsp_hit !== want.hit || rsp_block_x !== want.bx || rsp_block_y !== want.by ||
                rsp_block_z !== want.bz || rsp_normal_x !== want.nx ||
                rsp_normal_y !== want.ny || rsp_normal_z !== want.nz ||
                rsp_hit_distance !== want.hdist) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at cycle %0d: exp hit=%0d blk=%0d,%0d,%0d n=%0d,%0d,%0d d=%0d",
                           cycles, want.hit, want.bx, want.by, want.bz, want.nx, want.ny,
                           want.nz, want.hdist);
                  $display("   act hit=%0d blk=%0d,%0d,%0d n=%0d,%0d,%0d d=%0d",
                           rsp_hit, rsp_block_x, rsp_block_y, rsp_block_z,
                           rsp_normal_x, rsp_normal_y, rsp_normal_z, rsp_hit_distance);
               end
            end
         end
      end
   end

   initial begin
      stim_row_type rows [$];
      ray_rsp_type  none, start_hit;
      int burst, gap;
      none = '{default: '0};
      start_hit = '{hit: 1'b1, bx: 5'd16, by: 5'd16, bz: 5'd16, nx: 2'sd1, ny: -2'sd1,
                    nz: 2'sd0, hdist: '0};
      rows.push_back('{mk_cast(0, 0, 0, 4096, 0, 0, 262143), 1'b1, none});
      rows.push_back('{mk_cast(65536, 65536, 65536, 0, 0, 0, 262143), 1'b1, none});
      rows.push_back('{mk_cast(0, 0, 0, 0, 0, 0, 0), 1'b1, none});
      rows.push_back('{mk_write(31, 31, 31, 1), 1'b0, none});
      rows.push_back('{mk_write(0, 0, 0, 1), 1'b0, none});
      rows.push_back('{mk_write(16, 16, 16, 1), 1'b0, none});
      rows.push_back('{mk_write(15, 15, 16, 1), 1'b0, none});
      // solid start cell reports distance zero even with no range
      rows.push_back('{mk_cast(65536, 65536, 65536, -4096, 4096, 0, 0), 1'b1, start_hit});
      rows.push_back('{mk_cast(0, 0, 0, 0, 0, 0, 262143), 1'b1, none});
      rows.push_back('{mk_cast(40960, 65536, 65536, 4096, 0, 0, 262143), 1'b0, none});
      rows.push_back('{mk_cast(-131072, -131072, -131072, 32767, 32767, 32767, 262143),
                       1'b0, none});
      rows.push_back('{mk_cast(131071, 131071, 131071, -32768, -32768, -32768, 262143),
                       1'b0, none});
      // nearly parallel axes: tiny components round to zero
      rows.push_back('{mk_cast(65536, 65536, 40960, 1, -1, 32767, 262143), 1'b0, none});
      rows.push_back('{mk_cast(81920, 65536, 65536, -32767, 2, 0, 65536), 1'b0, none});
      // diagonal through a corner: face ties
      rows.push_back('{mk_cast(57344, 57344, 65536, 4096, 4096, 0, 262143), 1'b0, none});
      rows.push_back('{mk_cast(69632, 69632, 65536, -4096, -4096, 0, 262143), 1'b0, none});
      rows.push_back('{mk_write(16, 16, 16, 0), 1'b0, none});
      rows.push_back('{mk_cast(40960, 65536, 65536, 4096, 0, 0, 262143), 1'b0, none});
      rows.push_back('{mk_cast(-8192, -8192, -8192, 4096, 4096, 4096, 262143), 1'b0, none});
      rows.push_back('{mk_cast(135168, 126976, 126976, -4096, 0, 0, 8192), 1'b0, none});
      rows.push_back('{mk_cast(40960, 65536, 65536, 4096, 0, 0, 0), 1'b1, none});
      rows.push_back('{mk_write(0, 0, 0, 0), 1'b0, none});

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      burst = $urandom_range(1, 40);
      for (int i = 0; i < rows.size() + RANDOM_ITEMS; i++) begin
         if (i < rows.size()) send(rows[i].req, rows[i].known, rows[i].rsp);
         else send(rand_req(), 1'b0, none);
         burst--;
         if (burst == 0) begin
            burst = $urandom_range(1, 40);
            gap = $urandom_range(1, 300);
            start <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      start <= 1'b0;
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("requests: %0d writes, %0d casts; responses %0d, hits %0d, mismatches %0d",
               writes_sent, casts_sent, rsp_seen, hits_seen, mismatches);
      if (mismatches == 0 && pending_hits.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
`default_nettype wire
